@@ rtl/core/bounded_random_walk_node_step_defines.svh @@
// Assertion macros shared by the random walk node RTL.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef BOUNDED_RANDOM_WALK_NODE_STEP_DEFINES_SVH
`define BOUNDED_RANDOM_WALK_NODE_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define BRWN_ASSERT_IMPL(label, cond, res) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (res)) \
      else $error("brwn: assertion failed");
`define BRWN_ASSERT_NEXT(label, cond, res) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (res)) \
      else $error("brwn: assertion failed");
`else
`define BRWN_ASSERT_IMPL(label, cond, res)
`define BRWN_ASSERT_NEXT(label, cond, res)
`endif

`endif

@@ rtl/core/brwn_pkg.sv @@
// Shared types, codes, widths and the arctangent table for the random walk node.
// Used by brwn_cordic and bounded_random_walk_node_step; no dependencies.
package brwn_pkg;

   localparam int COORD_W    = 32;
   localparam int HEAD_W     = 16;
   localparam int WALL_W     = 3;
   localparam int SPEED_W    = 16;
   localparam int TIME_W     = 16;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 88;
   localparam int TURN_W     = 24;
   localparam int TBL_IDX_W  = 5;
   localparam int CD_W       = 34;
   localparam int Z_W        = 24;
   localparam int TRIG_W     = 32;

   localparam logic signed [CD_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;
   localparam logic signed [CD_W-1:0] UNIT_ONE  = 34'sh040000000;
   localparam logic [HEAD_W-1:0] HALF_TURN = 16'h8000;

   typedef enum logic [OP_W-1:0] {
      OP_ADVANCE = 2'd0,
      OP_SET     = 2'd1,
      OP_PLACE   = 2'd2
   } op_type;

   typedef enum logic [WALL_W-1:0] {
      WALL_NONE  = 3'd0,
      WALL_XLOW  = 3'd1,
      WALL_XHIGH = 3'd2,
      WALL_YLOW  = 3'd3,
      WALL_YHIGH = 3'd4
   } wall_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LOW  = 2'd0,
      CSR_X_HIGH = 2'd1,
      CSR_Y_LOW  = 2'd2,
      CSR_Y_HIGH = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIRROR,
      ST_TRIG_WAIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACCUM,
      ST_MOVE,
      ST_DONE
   } step_state_type;

   typedef enum logic [1:0] {
      CD_IDLE,
      CD_RUN,
      CD_ROT
   } cordic_state_type;

   // Arctangent of 2^-i in units of 2^-24 of a full turn.
   function automatic logic signed [Z_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         5'd0:    r = 24'sd2097152;
         5'd1:    r = 24'sd1238021;
         5'd2:    r = 24'sd654136;
         5'd3:    r = 24'sd332050;
         5'd4:    r = 24'sd166669;
         5'd5:    r = 24'sd83416;
         5'd6:    r = 24'sd41718;
         5'd7:    r = 24'sd20860;
         5'd8:    r = 24'sd10430;
         5'd9:    r = 24'sd5215;
         5'd10:   r = 24'sd2608;
         5'd11:   r = 24'sd1304;
         5'd12:   r = 24'sd652;
         5'd13:   r = 24'sd326;
         5'd14:   r = 24'sd163;
         5'd15:   r = 24'sd81;
         5'd16:   r = 24'sd41;
         5'd17:   r = 24'sd20;
         5'd18:   r = 24'sd10;
         5'd19:   r = 24'sd5;
         5'd20:   r = 24'sd3;
         5'd21:   r = 24'sd1;
         5'd22:   r = 24'sd1;
         default: r = 24'sd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/brwn_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of a turn-fraction heading.
// One micro-rotation per cycle through the same shifters and adders; uses brwn_pkg.
module brwn_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic        [brwn_pkg::HEAD_W-1:0]    heading,
   output logic                                  done,
   output logic signed [brwn_pkg::TRIG_W-1:0]    cos_out,
   output logic signed [brwn_pkg::TRIG_W-1:0]    sin_out
);
   import brwn_pkg::*;

   localparam int ITER_W   = $clog2(ANGLE_BITS);
   localparam int CLR_BITS = (ANGLE_BITS < TURN_W) ? TURN_W - ANGLE_BITS : 0;
   localparam logic [TURN_W-1:0] ANGLE_MASK = ~((TURN_W'(1) << CLR_BITS) - TURN_W'(1));
   localparam logic [ITER_W-1:0] LAST_ITER  = ITER_W'(ANGLE_BITS - 1);

   cordic_state_type           state_ff, state_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [CD_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic [1:0]                 quad_ff, quad_in;
   logic signed [TRIG_W-1:0]   cos_ff, cos_in, sin_ff, sin_in;
   logic                       done_ff, done_in;

   logic [TURN_W-1:0]          turn;
   logic signed [CD_W-1:0]     dx, dy, cx, cy;
   logic signed [Z_W-1:0]      step;
   logic signed [TRIG_W-1:0]   cx_t, cy_t;

   assign turn = {heading, {(TURN_W - HEAD_W){1'b0}}} & ANGLE_MASK;
   assign dx   = y_ff >>> iter_ff;
   assign dy   = x_ff >>> iter_ff;
   assign step = atan_turn(TBL_IDX_W'(iter_ff));
   assign cx   = (x_ff > UNIT_ONE) ? UNIT_ONE : ((x_ff < -UNIT_ONE) ? -UNIT_ONE : x_ff);
   assign cy   = (y_ff > UNIT_ONE) ? UNIT_ONE : ((y_ff < -UNIT_ONE) ? -UNIT_ONE : y_ff);
   assign cx_t = cx[TRIG_W-1:0];
   assign cy_t = cy[TRIG_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CD_IDLE: begin
            if (start) state_in = CD_RUN;
         end
         CD_RUN: begin
            if (iter_ff == LAST_ITER) state_in = CD_ROT;
         end
         CD_ROT: begin
            state_in = CD_IDLE;
         end
         default: begin
            state_in = CD_IDLE;
         end
      endcase
   end

   always_comb begin
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      done_in = 1'b0;
      unique case (state_ff)
         CD_IDLE: begin
            if (start) begin
               x_in    = CORDIC_X0;
               y_in    = '0;
               z_in    = signed'({2'b00, turn[TURN_W-3:0]});
               quad_in = turn[TURN_W-1:TURN_W-2];
               iter_in = '0;
            end
         end
         CD_RUN: begin
            if (z_ff[Z_W-1] == 1'b0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - step;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + step;
            end
            iter_in = iter_ff + ITER_W'(1);
         end
         CD_ROT: begin
            done_in = 1'b1;
            case (quad_ff)
               2'd0: begin
                  cos_in = cx_t;
                  sin_in = cy_t;
               end
               2'd1: begin
                  cos_in = -cy_t;
                  sin_in = cx_t;
               end
               2'd2: begin
                  cos_in = -cx_t;
                  sin_in = -cy_t;
               end
               default: begin
                  cos_in = cy_t;
                  sin_in = -cx_t;
               end
            endcase
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ rtl/core/bounded_random_walk_node_step.sv @@
// Top level of the bounded random walk node: wall registers, node state and step sequencer.
// Depends on brwn_pkg, brwn_cordic and the assertion macros header.
//
//   Channel  Dir  Handshake              Contents
//   req      in   req_tvalid/req_tready  tuser: operation; tdata: step operands
//   rsp      out  rsp_tvalid/rsp_tready  tdata: position, heading, last wall
//   csr      in   csr_valid/csr_ready    csr_index, csr_data; always ready
//
// An advance item occupies the block through the CORDIC loop (one micro-rotation a cycle,
// overlapping the speed times elapsed product) and four more passes of the shared 17 x 32
// multiplier. Set and place items go straight from the idle state to the done state.
// req_tready is high only in the idle state. A finished result waits in the output register
// while the block takes the next item; that item's result is held in the done state, with
// req_tready low, until the register drains. Reset is synchronous.
`include "bounded_random_walk_node_step_defines.svh"

module bounded_random_walk_node_step #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // elapsed, place_x, place_y, new_speed, new_heading
   input  logic [brwn_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic [brwn_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pos_x_out, pos_y_out, heading_out, wall_out, zero padding
   output logic [brwn_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [brwn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [brwn_pkg::COORD_W-1:0]        csr_data
);
   import brwn_pkg::*;

   localparam int MUL_A_W = SPEED_W + 1;
   localparam int PROD_W  = MUL_A_W + TRIG_W;
   localparam int ACC_W   = 64;
   localparam int FRAC_SH = 38;
   localparam int DELTA_W = ACC_W - FRAC_SH;
   localparam int PAD_W   = RSP_DATA_W - (2 * COORD_W + HEAD_W + WALL_W);
   localparam logic signed [COORD_W-1:0] MAX_COORD = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam logic signed [COORD_W-1:0] MIN_COORD = {1'b1, {(COORD_W - 1){1'b0}}};
   localparam logic signed [COORD_W-1:0] X_HIGH_RESET = 32'sd6553600;
   localparam logic signed [COORD_W-1:0] Y_HIGH_RESET = 32'sd6553600;
   localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (FRAC_SH - 1);

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W+1:0] v
   );
      logic signed [COORD_W-1:0] r;
      if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
         r = v[COORD_W-1:0];
      end else if (v[COORD_W+1]) begin
         r = MIN_COORD;
      end else begin
         r = MAX_COORD;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] mirror_coord(
      input logic signed [COORD_W-1:0] w,
      input logic signed [COORD_W-1:0] p
   );
      logic signed [COORD_W+1:0] d;
      d = {w[COORD_W-1], w, 1'b0} - {{2{p[COORD_W-1]}}, p};
      return sat_coord(d);
   endfunction

   step_state_type              state_ff, state_in;
   logic signed [COORD_W-1:0]   x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic signed [COORD_W-1:0]   y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic signed [COORD_W-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [SPEED_W-1:0]          speed_ff, speed_in;
   logic [HEAD_W-1:0]           heading_ff, heading_in;
   wall_type                    last_wall_ff, last_wall_in;
   logic [TIME_W-1:0]           el_ff, el_in;
   logic [SPEED_W+TIME_W-1:0]   se_ff, se_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        axis_ff, axis_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   op_type                      op;
   logic                        req_fire, rsp_free;
   logic signed [COORD_W-1:0]   mir_pos_x, mir_pos_y;
   logic [HEAD_W-1:0]           mir_heading;
   wall_type                    mir_wall;
   logic                        trig_done;
   logic signed [TRIG_W-1:0]    trig_cos, trig_sin, trig_sel;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [TRIG_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic signed [ACC_W-1:0]     rnd;
   logic [DELTA_W-1:0]          delta;
   logic signed [COORD_W-1:0]   move_base, move_pos;
   logic signed [COORD_W+1:0]   move_sum;

   assign op         = op_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   brwn_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_MIRROR),
      .heading (mir_heading),
      .done    (trig_done),
      .cos_out (trig_cos),
      .sin_out (trig_sin)
   );

   // Wall handling: x first, then y on the heading that x left behind.
   always_comb begin
      mir_pos_x   = pos_x_ff;
      mir_pos_y   = pos_y_ff;
      mir_heading = heading_ff;
      mir_wall    = last_wall_ff;
      if (pos_x_ff <= x_low_ff) begin
         mir_pos_x = mirror_coord(x_low_ff, pos_x_ff);
         if (mir_wall != WALL_XLOW) begin
            mir_heading = HALF_TURN - mir_heading;
            mir_wall    = WALL_XLOW;
         end
      end else if (pos_x_ff >= x_high_ff) begin
         mir_pos_x = mirror_coord(x_high_ff, pos_x_ff);
         if (mir_wall != WALL_XHIGH) begin
            mir_heading = HALF_TURN - mir_heading;
            mir_wall    = WALL_XHIGH;
         end
      end
      if (pos_y_ff <= y_low_ff) begin
         mir_pos_y = mirror_coord(y_low_ff, pos_y_ff);
         if (mir_wall != WALL_YLOW) begin
            mir_heading = HEAD_W'(0) - mir_heading;
            mir_wall    = WALL_YLOW;
         end
      end else if (pos_y_ff >= y_high_ff) begin
         mir_pos_y = mirror_coord(y_high_ff, pos_y_ff);
         if (mir_wall != WALL_YHIGH) begin
            mir_heading = HEAD_W'(0) - mir_heading;
            mir_wall    = WALL_YHIGH;
         end
      end
   end

   // Shared multiplier: speed * elapsed, then the two halves of that product by cos or sin.
   always_comb begin
      trig_sel = axis_ff ? trig_sin : trig_cos;
      case (state_ff)
         ST_MIRROR: begin
            mul_a = signed'({1'b0, speed_ff});
            mul_b = signed'({{(TRIG_W - TIME_W){1'b0}}, el_ff});
         end
         ST_MUL_HI: begin
            mul_a = signed'({1'b0, se_ff[SPEED_W+TIME_W-1:TIME_W]});
            mul_b = trig_sel;
         end
         default: begin
            mul_a = signed'({1'b0, se_ff[TIME_W-1:0]});
            mul_b = trig_sel;
         end
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign rnd       = acc_ff + ROUND_HALF;
   assign delta     = rnd[ACC_W-1:FRAC_SH];
   assign move_base = axis_ff ? pos_y_ff : pos_x_ff;
   assign move_sum  = {{2{move_base[COORD_W-1]}}, move_base}
                    + {{(COORD_W + 2 - DELTA_W){delta[DELTA_W-1]}}, delta};
   assign move_pos  = sat_coord(move_sum);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (op == OP_ADVANCE) ? ST_MIRROR : ST_DONE;
            end
         end
         ST_MIRROR: begin
            state_in = ST_TRIG_WAIT;
         end
         ST_TRIG_WAIT: begin
            if (trig_done) state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            state_in = axis_ff ? ST_DONE : ST_MUL_LO;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      speed_in     = speed_ff;
      heading_in   = heading_ff;
      last_wall_in = last_wall_ff;
      el_in        = el_ff;
      se_in        = se_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (op)
                  OP_ADVANCE: begin
                     el_in = req_tdata[15:0];
                  end
                  OP_SET: begin
                     speed_in     = req_tdata[95:80];
                     heading_in   = req_tdata[111:96];
                     last_wall_in = WALL_NONE;
                  end
                  OP_PLACE: begin
                     pos_x_in     = signed'(req_tdata[47:16]);
                     pos_y_in     = signed'(req_tdata[79:48]);
                     speed_in     = req_tdata[95:80];
                     heading_in   = req_tdata[111:96];
                     last_wall_in = WALL_NONE;
                  end
                  default: begin
                     el_in = el_ff;
                  end
               endcase
            end
         end
         ST_MIRROR: begin
            pos_x_in     = mir_pos_x;
            pos_y_in     = mir_pos_y;
            heading_in   = mir_heading;
            last_wall_in = mir_wall;
            prod_in      = mul_p;
         end
         ST_TRIG_WAIT: begin
            se_in   = prod_ff[SPEED_W+TIME_W-1:0];
            axis_in = 1'b0;
         end
         ST_MUL_LO: begin
            prod_in = mul_p;
         end
         ST_MUL_HI: begin
            acc_in  = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            prod_in = mul_p;
         end
         ST_ACCUM: begin
            acc_in = acc_ff + signed'({prod_ff[ACC_W-TIME_W-1:0], {TIME_W{1'b0}}});
         end
         ST_MOVE: begin
            if (axis_ff) begin
               pos_y_in = move_pos;
            end else begin
               pos_x_in = move_pos;
            end
            axis_in = 1'b1;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, last_wall_ff, heading_ff, pos_y_ff, pos_x_ff};
            end
         end
         default: begin
            axis_in = axis_ff;
         end
      endcase
   end

   always_comb begin
      x_low_in  = x_low_ff;
      x_high_in = x_high_ff;
      y_low_in  = y_low_ff;
      y_high_in = y_high_ff;
      if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_X_LOW:  x_low_in  = signed'(csr_data);
            CSR_X_HIGH: x_high_in = signed'(csr_data);
            CSR_Y_LOW:  y_low_in  = signed'(csr_data);
            CSR_Y_HIGH: y_high_in = signed'(csr_data);
            default:    x_low_in  = x_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_low_ff     <= '0;
         x_high_ff    <= X_HIGH_RESET;
         y_low_ff     <= '0;
         y_high_ff    <= Y_HIGH_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         speed_ff     <= '0;
         heading_ff   <= '0;
         last_wall_ff <= WALL_NONE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_low_ff     <= x_low_in;
         x_high_ff    <= x_high_in;
         y_low_ff     <= y_low_in;
         y_high_ff    <= y_high_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         speed_ff     <= speed_in;
         heading_ff   <= heading_in;
         last_wall_ff <= last_wall_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      el_ff       <= el_in;
      se_ff       <= se_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BRWN_ASSERT_IMPL(a_trig_done_while_waiting, trig_done, state_ff == ST_TRIG_WAIT)
   `BRWN_ASSERT_NEXT(a_advance_starts_mirror, req_fire && op == OP_ADVANCE, state_ff == ST_MIRROR)
   `BRWN_ASSERT_NEXT(a_y_move_finishes, state_ff == ST_MOVE && axis_ff, state_ff == ST_DONE)
   `BRWN_ASSERT_NEXT(a_done_loads_result, state_ff == ST_DONE && rsp_free, rsp_tvalid)

endmodule
